### hw/rtl/apbd_pkg.sv
package apbd_pkg;

    localparam int unsigned MaxCoeffs = 512;
    localparam int unsigned CountW    = 10;
    localparam int unsigned GrpW      = 7;   // group counter, shared by raw bytes and fill runs
    localparam int unsigned TotW      = 7;   // up to MaxCoeffs/8 groups

    typedef enum logic [1:0] {
        ST_TAG,
        ST_RAW,
        ST_FILL
    } t_state;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_BAD_TAG = 2'd1,
        ERR_PADDING = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        REG_COUNT    = 2'd0,
        REG_TAG_ZERO = 2'd1,
        REG_TAG_ONE  = 2'd2,
        REG_TAG_RAW  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [7:0] presence_bits;
        logic [3:0] flag_count;
        logic [5:0] group_index;
        t_err       error_code;
        logic       last;
    } t_result;

    function automatic logic [CountW-1:0] eff_count(input logic [CountW-1:0] cnt);
        if (cnt > CountW'(MaxCoeffs)) begin
            return CountW'(MaxCoeffs);
        end
        return cnt;
    endfunction

    function automatic logic [TotW-1:0] group_total(input logic [CountW-1:0] cnt);
        logic [CountW:0] sum;
        sum = {1'b0, eff_count(cnt)} + (CountW+1)'(7);
        return TotW'(sum >> 3);
    endfunction

    // valid flags in group g, clipped to 0..8
    function automatic logic [3:0] valid_in_group(input logic [CountW-1:0] cnt,
                                                  input logic [GrpW-1:0]   g);
        logic [CountW:0] eff;
        logic [CountW:0] base;
        logic [CountW:0] diff;
        eff  = {1'b0, eff_count(cnt)};
        base = {1'b0, g, 3'b000};
        diff = eff - base;
        if (eff <= base) begin
            return 4'd0;
        end else if (diff >= (CountW+1)'(8)) begin
            return 4'd8;
        end
        return diff[3:0];
    endfunction

    function automatic logic [7:0] low_mask(input logic [3:0] n);
        logic [8:0] m;
        m = (9'd1 << n) - 9'd1;
        return m[7:0];
    endfunction

endpackage

### hw/rtl/apbd_if.sv
interface apbd_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface apbd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] presence_bits;
    logic [3:0] flag_count;
    logic [5:0] group_index;
    logic [1:0] error_code;
    logic       last;

    modport source (output valid, output presence_bits, output flag_count,
                    output group_index, output error_code, output last, input ready);
    modport sink   (input valid, input presence_bits, input flag_count,
                    input group_index, input error_code, input last, output ready);
endinterface

interface apbd_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [9:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/adaptive_presence_bitmap_decoder_top.sv
// A raw byte, zero-count or unknown-tag result is presented the cycle after its
// request; a fill tag moves the state to ST_FILL, which then registers the groups.
// Raw packed bytes: one request per cycle. Fill tags: the tag request, then one
// group per cycle out of the shared group-count unit, ceil(count/8) groups, with
// no request taken until the last group is registered. Output stalls hold input.
// Reset (synchronous, active low): awaiting a tag, output empty, registers at
// count 0, tags 0 / 1 / 2.
module adaptive_presence_bitmap_decoder_top (
    input  logic          i_clk,
    input  logic          i_rst_n,
    apbd_stream_if.sink   i_stream,
    apbd_result_if.source o_result,
    apbd_cfg_if.sink      i_cfg
);

    apbd_pkg::t_state             r_state, n_state;
    logic [apbd_pkg::GrpW-1:0]    r_grp, n_grp;
    logic                         r_ones, n_ones;
    logic [apbd_pkg::CountW-1:0]  r_count;
    logic [7:0]                   r_tag_zero, r_tag_one, r_tag_raw;

    logic                         r_out_valid, n_out_valid;
    apbd_pkg::t_result            r_out, n_out;

    logic                         slot_free;
    logic                         take;
    logic [apbd_pkg::TotW-1:0]    groups;
    logic [3:0]                   unit_n;
    logic [7:0]                   unit_mask;
    logic                         unit_last;
    logic [7:0]                   in_byte;
    logic                         is_zero, is_one, is_raw;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_tag_zero <= 8'd0;
            r_tag_one  <= 8'd1;
            r_tag_raw  <= 8'd2;
        end else if (i_cfg.valid) begin
            unique case (apbd_pkg::t_reg_idx'(i_cfg.index))
                apbd_pkg::REG_COUNT:    r_count    <= i_cfg.data;
                apbd_pkg::REG_TAG_ZERO: r_tag_zero <= i_cfg.data[7:0];
                apbd_pkg::REG_TAG_ONE:  r_tag_one  <= i_cfg.data[7:0];
                apbd_pkg::REG_TAG_RAW:  r_tag_raw  <= i_cfg.data[7:0];
                default:                ;
            endcase
        end
    end

    // shared group unit: always works on r_grp, for fill runs and raw bytes alike
    assign groups    = apbd_pkg::group_total(r_count);
    assign unit_n    = apbd_pkg::valid_in_group(r_count, r_grp);
    assign unit_mask = apbd_pkg::low_mask(unit_n);
    assign unit_last = ({1'b0, r_grp} + 8'd1) >= {1'b0, groups};

    assign slot_free      = !r_out_valid || o_result.ready;
    assign i_stream.ready = slot_free && (r_state != apbd_pkg::ST_FILL);
    assign take           = i_stream.valid && i_stream.ready;
    assign in_byte        = i_stream.stream_byte;

    assign is_zero = (in_byte == r_tag_zero);
    assign is_one  = (in_byte == r_tag_one);
    assign is_raw  = (in_byte == r_tag_raw);

    always_comb begin
        n_state     = r_state;
        n_grp       = r_grp;
        n_ones      = r_ones;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out       = r_out;

        unique case (r_state)
            apbd_pkg::ST_TAG: begin
                if (take) begin
                    if (is_zero || is_one || is_raw) begin
                        if (groups == '0) begin
                            n_out_valid = 1'b1;
                            n_out       = '{8'd0, 4'd0, 6'd0, apbd_pkg::ERR_OK, 1'b1};
                        end else if (is_zero || is_one) begin
                            n_state = apbd_pkg::ST_FILL;
                            n_ones  = !is_zero;
                            n_grp   = '0;
                        end else begin
                            n_state = apbd_pkg::ST_RAW;
                            n_grp   = '0;
                        end
                    end else begin
                        n_out_valid = 1'b1;
                        n_out       = '{8'd0, 4'd0, 6'd0, apbd_pkg::ERR_BAD_TAG, 1'b1};
                    end
                end
            end
            apbd_pkg::ST_RAW: begin
                if (take) begin
                    n_out_valid       = 1'b1;
                    n_out.presence_bits = in_byte & unit_mask;
                    n_out.flag_count  = unit_n;
                    n_out.group_index = r_grp[5:0];
                    n_out.last        = unit_last;
                    // padding bits above the valid flags of the final byte
                    if (unit_last && (unit_n < 4'd8) && ((in_byte & ~unit_mask) != 8'd0)) begin
                        n_out.error_code = apbd_pkg::ERR_PADDING;
                    end else begin
                        n_out.error_code = apbd_pkg::ERR_OK;
                    end
                    if (unit_last) begin
                        n_state = apbd_pkg::ST_TAG;
                        n_grp   = '0;
                    end else begin
                        n_grp = r_grp + apbd_pkg::GrpW'(1);
                    end
                end
            end
            apbd_pkg::ST_FILL: begin
                if (slot_free) begin
                    n_out_valid         = 1'b1;
                    n_out.presence_bits = r_ones ? unit_mask : 8'd0;
                    n_out.flag_count    = unit_n;
                    n_out.group_index   = r_grp[5:0];
                    n_out.error_code    = apbd_pkg::ERR_OK;
                    n_out.last          = unit_last;
                    if (unit_last) begin
                        n_state = apbd_pkg::ST_TAG;
                        n_grp   = '0;
                    end else begin
                        n_grp = r_grp + apbd_pkg::GrpW'(1);
                    end
                end
            end
            default: begin
                n_state = apbd_pkg::ST_TAG;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= apbd_pkg::ST_TAG;
            r_grp       <= '0;
            r_ones      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_grp       <= n_grp;
            r_ones      <= n_ones;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.presence_bits = r_out.presence_bits;
    assign o_result.flag_count    = r_out.flag_count;
    assign o_result.group_index   = r_out.group_index;
    assign o_result.error_code    = r_out.error_code;
    assign o_result.last          = r_out.last;

endmodule
